>>> hdl/kruskal_union_find_edge_filter_unit_assert.svh
// Assertion macros used by the edge filter RTL.
`ifndef KRUSKAL_UNION_FIND_EDGE_FILTER_UNIT_ASSERT_SVH
`define KRUSKAL_UNION_FIND_EDGE_FILTER_UNIT_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define KUFE_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define KUFE_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define KUFE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/kufe_pkg.sv
// Constants, types and helper functions of the union-find edge filter.
`timescale 1ns / 1ps
`default_nettype none

package kufe_pkg;

   localparam int VERTEX_SLOTS = 4096;
   localparam int ADDR_BITS    = $clog2(VERTEX_SLOTS);
   localparam int ID_BITS      = 12;
   localparam int WIDTH_BITS   = 6;
   localparam int RANK_BITS    = 4;
   localparam int COUNT_BITS   = ID_BITS + 1;
   localparam int WORD_BITS    = RANK_BITS + ADDR_BITS;

   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 24;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 12;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH      = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_VERTICES = 1'b1;

   localparam logic [WIDTH_BITS-1:0] GRID_WIDTH_RESET = 6'd63;
   localparam logic [ID_BITS-1:0]    ACTIVE_RESET     = 12'd3969;
   localparam logic [RANK_BITS-1:0]  RANK_MAX         = 4'd15;

   localparam int REM_BITS_PER_STEP = 2;
   localparam int REM_STEPS         = ID_BITS / REM_BITS_PER_STEP;
   localparam int REM_CNT_BITS      = $clog2(REM_STEPS + 1);

   // One store entry: rank beside the parent pointer.
   typedef struct packed {
      logic [RANK_BITS-1:0] rank;
      logic [ADDR_BITS-1:0] parent;
   } node_type;

   // Clamp the active count to the last usable slot.
   function automatic logic [ID_BITS-1:0] eff_count(input logic [ID_BITS-1:0] active);
      if (int'(active) > VERTEX_SLOTS - 1) begin
         return ID_BITS'(VERTEX_SLOTS - 1);
      end
      return active;
   endfunction

endpackage

`default_nettype wire

>>> hdl/kufe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module kufe_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 4096,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/kruskal_union_find_edge_filter_unit.sv
// Top level of the Kruskal union-find edge filter for grid mazes.
`timescale 1ns / 1ps
`default_nettype none
`include "kruskal_union_find_edge_filter_unit_assert.svh"

// Takes one grid edge per req word (two vertex ids), finds the set of each
// endpoint in a union-find store with union by rank and path compression,
// merges them when they differ and returns one rsp word: accepted, the grid
// direction from the first vertex to the second, a bad-id flag and the count
// of sets left. The store is one RAM of VERTEX_SLOTS entries holding parent
// and rank. An item is taken in idle, then walks from the first endpoint to
// its root, walks that path again to point every node not yet on the root
// straight at it, does the same for the second endpoint (whose walk sees the
// first path already compressed), writes the merge when the roots differ,
// raises the surviving root's rank when the ranks were equal, and reports.
// Every pointer step is one read of the single RAM read port. The column
// remainder of the second id runs beside the walks in a compare-subtract
// unit, two bits a cycle; an item with a bad id skips the walks and waits
// only for that remainder. A finished rsp word waits in the output register,
// and the item holds in its last state while that register is full and not
// being taken. After reset and after every write of active_vertices a
// clearing pass rewrites every slot of the store while req_tready stays
// low; csr writes are taken at any time.
module kruskal_union_find_edge_filter_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [kufe_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [kufe_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [11:0] from_vertex, [23:12] to_vertex
   input  wire logic [kufe_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] accepted, [3:1] direction, [16:4] sets_left, [23:17] zero
   output logic [kufe_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // [0] bad_vertex
   output logic                                     rsp_tuser
);

   import kufe_pkg::*;

   localparam logic [2:0] DIR_TOP    = 3'd0;
   localparam logic [2:0] DIR_RIGHT  = 3'd1;
   localparam logic [2:0] DIR_BOTTOM = 3'd2;
   localparam logic [2:0] DIR_LEFT   = 3'd3;
   localparam logic [2:0] DIR_NONE   = 3'd4;

   localparam logic [ADDR_BITS-1:0] LAST_SLOT = ADDR_BITS'(VERTEX_SLOTS - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FIND_A, S_COMP_A, S_FIND_B, S_COMP_B, S_MERGE, S_RANK, S_DONE
   } state_type;

   // Registers
   state_type                state_ff, state_in;
   logic [ADDR_BITS-1:0]     clr_ff, clr_in;
   logic [WIDTH_BITS-1:0]    grid_width_ff, grid_width_in;
   logic [ID_BITS-1:0]       active_ff, active_in;
   logic [COUNT_BITS-1:0]    set_total_ff, set_total_in;
   logic [ID_BITS-1:0]       vtx_a_ff, vtx_a_in;
   logic [ID_BITS-1:0]       vtx_b_ff, vtx_b_in;
   logic                     item_bad_ff, item_bad_in;
   logic                     merged_ff, merged_in;
   logic [ADDR_BITS-1:0]     cur_ff, cur_in;
   logic [ADDR_BITS-1:0]     root_a_ff, root_a_in;
   logic [ADDR_BITS-1:0]     root_b_ff, root_b_in;
   logic [RANK_BITS-1:0]     rank_a_ff, rank_a_in;
   logic [RANK_BITS-1:0]     rank_b_ff, rank_b_in;
   logic [WIDTH_BITS-1:0]    rem_ff, rem_in;
   logic [ID_BITS-1:0]       rem_shift_ff, rem_shift_in;
   logic [REM_CNT_BITS-1:0]  rem_cnt_ff, rem_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_acc_ff, rsp_acc_in;
   logic [2:0]               rsp_dir_ff, rsp_dir_in;
   logic                     rsp_bad_ff, rsp_bad_in;
   logic [COUNT_BITS-1:0]    rsp_sets_ff, rsp_sets_in;

   // Store port
   logic                     ram_wr_en;
   logic [ADDR_BITS-1:0]     ram_wr_addr;
   node_type                 ram_wr_node;
   logic [ADDR_BITS-1:0]     ram_rd_addr;
   logic [WORD_BITS-1:0]     ram_rd_data;
   node_type                 rd_node;

   // Decoded request and helpers
   logic [ID_BITS-1:0]       eff;
   logic [COUNT_BITS-1:0]    set_limit;
   logic [ID_BITS-1:0]       req_a;
   logic [ID_BITS-1:0]       req_b;
   logic                     req_bad;
   logic                     req_fire;
   logic                     rsp_free;
   logic [WIDTH_BITS-1:0]    rem_step;
   logic [ID_BITS-1:0]       rem_shift_step;
   logic [2:0]               dir_code;

   kufe_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (VERTEX_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_node),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_node    = node_type'(ram_rd_data);
   assign eff        = eff_count(active_ff);
   assign set_limit  = {1'b0, eff} + COUNT_BITS'(1);
   assign req_a      = req_tdata[ID_BITS-1:0];
   assign req_b      = req_tdata[2*ID_BITS-1:ID_BITS];
   assign req_bad    = (req_a == '0) || (req_b == '0) || (req_a > eff) || (req_b > eff);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Compare-subtract unit: advance the remainder of to_vertex by
   // grid_width two quotient bits per cycle, most significant bits first.
   always_comb begin
      logic [WIDTH_BITS:0] rem_work;
      logic [ID_BITS-1:0]  shift_work;
      rem_work   = {1'b0, rem_ff};
      shift_work = rem_shift_ff;
      for (int k = 0; k < REM_BITS_PER_STEP; k++) begin
         rem_work   = {rem_work[WIDTH_BITS-1:0], shift_work[ID_BITS-1]};
         shift_work = {shift_work[ID_BITS-2:0], 1'b0};
         if (rem_work >= {1'b0, grid_width_ff}) begin
            rem_work = rem_work - {1'b0, grid_width_ff};
         end
      end
      rem_step       = rem_work[WIDTH_BITS-1:0];
      rem_shift_step = shift_work;
   end

   // Direction from the first vertex to the second; first match wins.
   always_comb begin
      logic [COUNT_BITS-1:0] a_ext;
      logic [COUNT_BITS-1:0] b_ext;
      logic [COUNT_BITS-1:0] w_ext;
      a_ext = {1'b0, vtx_a_ff};
      b_ext = {1'b0, vtx_b_ff};
      w_ext = COUNT_BITS'(grid_width_ff);
      if (item_bad_ff || grid_width_ff == '0) begin
         dir_code = DIR_NONE;
      end else if (b_ext + w_ext == a_ext) begin
         dir_code = DIR_TOP;
      end else if (b_ext == a_ext + COUNT_BITS'(1) && rem_ff != WIDTH_BITS'(1)) begin
         dir_code = DIR_RIGHT;
      end else if (b_ext == a_ext + w_ext && vtx_b_ff <= eff) begin
         dir_code = DIR_BOTTOM;
      end else if (b_ext + COUNT_BITS'(1) == a_ext && rem_ff != '0) begin
         dir_code = DIR_LEFT;
      end else begin
         dir_code = DIR_NONE;
      end
   end

   // Sequencer: clear, walk, compress, merge, report.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      grid_width_in = grid_width_ff;
      active_in     = active_ff;
      set_total_in  = set_total_ff;
      vtx_a_in      = vtx_a_ff;
      vtx_b_in      = vtx_b_ff;
      item_bad_in   = item_bad_ff;
      merged_in     = merged_ff;
      cur_in        = cur_ff;
      root_a_in     = root_a_ff;
      root_b_in     = root_b_ff;
      rank_a_in     = rank_a_ff;
      rank_b_in     = rank_b_ff;
      rem_in        = rem_ff;
      rem_shift_in  = rem_shift_ff;
      rem_cnt_in    = rem_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_acc_in    = rsp_acc_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_bad_in    = rsp_bad_ff;
      rsp_sets_in   = rsp_sets_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_ff;
      ram_wr_node   = '{rank: rd_node.rank, parent: root_a_ff};
      ram_rd_addr   = cur_ff;

      // Advance the remainder unit while steps remain; a new item reloads it.
      if (rem_cnt_ff != '0) begin
         rem_in       = rem_step;
         rem_shift_in = rem_shift_step;
         rem_cnt_in   = rem_cnt_ff - REM_CNT_BITS'(1);
      end

      unique case (state_ff)
         S_CLEAR: begin
            // Make every slot its own root with rank zero.
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_node = '{rank: '0, parent: clr_ff};
            clr_in      = clr_ff + ADDR_BITS'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               vtx_a_in     = req_a;
               vtx_b_in     = req_b;
               item_bad_in  = req_bad;
               merged_in    = 1'b0;
               cur_in       = ADDR_BITS'(req_a);
               ram_rd_addr  = ADDR_BITS'(req_a);
               rem_in       = '0;
               rem_shift_in = req_b;
               rem_cnt_in   = REM_CNT_BITS'(REM_STEPS);
               state_in     = req_bad ? S_DONE : S_FIND_A;
            end
         end
         S_FIND_A: begin
            if (rd_node.parent == cur_ff) begin
               root_a_in   = cur_ff;
               rank_a_in   = rd_node.rank;
               cur_in      = ADDR_BITS'(vtx_a_ff);
               ram_rd_addr = ADDR_BITS'(vtx_a_ff);
               state_in    = S_COMP_A;
            end else begin
               cur_in      = rd_node.parent;
               ram_rd_addr = rd_node.parent;
            end
         end
         S_COMP_A: begin
            if (rd_node.parent != root_a_ff) begin
               // Point this node straight at the root, keep its rank.
               ram_wr_en   = 1'b1;
               ram_wr_addr = cur_ff;
               ram_wr_node = '{rank: rd_node.rank, parent: root_a_ff};
               cur_in      = rd_node.parent;
               ram_rd_addr = rd_node.parent;
            end else begin
               cur_in      = ADDR_BITS'(vtx_b_ff);
               ram_rd_addr = ADDR_BITS'(vtx_b_ff);
               state_in    = S_FIND_B;
            end
         end
         S_FIND_B: begin
            if (rd_node.parent == cur_ff) begin
               root_b_in   = cur_ff;
               rank_b_in   = rd_node.rank;
               cur_in      = ADDR_BITS'(vtx_b_ff);
               ram_rd_addr = ADDR_BITS'(vtx_b_ff);
               state_in    = S_COMP_B;
            end else begin
               cur_in      = rd_node.parent;
               ram_rd_addr = rd_node.parent;
            end
         end
         S_COMP_B: begin
            if (rd_node.parent != root_b_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cur_ff;
               ram_wr_node = '{rank: rd_node.rank, parent: root_b_ff};
               cur_in      = rd_node.parent;
               ram_rd_addr = rd_node.parent;
            end else if (root_a_ff == root_b_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            merged_in = 1'b1;
            if (set_total_ff > COUNT_BITS'(1)) begin
               set_total_in = set_total_ff - COUNT_BITS'(1);
            end
            ram_wr_en = 1'b1;
            if (rank_a_ff < rank_b_ff) begin
               ram_wr_addr = root_a_ff;
               ram_wr_node = '{rank: rank_a_ff, parent: root_b_ff};
               state_in    = S_DONE;
            end else begin
               ram_wr_addr = root_b_ff;
               ram_wr_node = '{rank: rank_b_ff, parent: root_a_ff};
               state_in    = (rank_a_ff == rank_b_ff) ? S_RANK : S_DONE;
            end
         end
         S_RANK: begin
            // Equal ranks: raise the surviving root, saturating.
            ram_wr_en   = (rank_a_ff != RANK_MAX);
            ram_wr_addr = root_a_ff;
            ram_wr_node = '{rank: rank_a_ff + RANK_BITS'(1), parent: root_a_ff};
            state_in    = S_DONE;
         end
         S_DONE: begin
            // Hold until the remainder is ready and the output slot is free.
            if (rem_cnt_ff == '0 && rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = merged_ff;
               rsp_dir_in   = dir_code;
               rsp_bad_in   = item_bad_ff;
               rsp_sets_in  = set_total_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase

      // Register writes; a new active count restarts the store.
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_WIDTH: begin
               grid_width_in = csr_wr_data[WIDTH_BITS-1:0];
            end
            CSR_ACTIVE_VERTICES: begin
               active_in    = csr_wr_data[ID_BITS-1:0];
               set_total_in = {1'b0, eff_count(csr_wr_data[ID_BITS-1:0])} + COUNT_BITS'(1);
               clr_in       = '0;
               state_in     = S_CLEAR;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         grid_width_ff <= GRID_WIDTH_RESET;
         active_ff     <= ACTIVE_RESET;
         set_total_ff  <= {1'b0, eff_count(ACTIVE_RESET)} + COUNT_BITS'(1);
         rem_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         grid_width_ff <= grid_width_in;
         active_ff     <= active_in;
         set_total_ff  <= set_total_in;
         rem_cnt_ff    <= rem_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      vtx_a_ff     <= vtx_a_in;
      vtx_b_ff     <= vtx_b_in;
      item_bad_ff  <= item_bad_in;
      merged_ff    <= merged_in;
      cur_ff       <= cur_in;
      root_a_ff    <= root_a_in;
      root_b_ff    <= root_b_in;
      rank_a_ff    <= rank_a_in;
      rank_b_ff    <= rank_b_in;
      rem_ff       <= rem_in;
      rem_shift_ff <= rem_shift_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_sets_ff  <= rsp_sets_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_sets_ff, rsp_dir_ff, rsp_acc_ff});
   assign rsp_tuser  = rsp_bad_ff;

   `KUFE_ASSERT_IMPLIES(a_merge_distinct_roots, state_ff == S_MERGE, root_a_ff != root_b_ff, "merge of one set with itself")
   `KUFE_ASSERT_NEXT(a_merge_counts_down, state_ff == S_MERGE && set_total_ff > COUNT_BITS'(1), set_total_ff == $past(set_total_ff) - COUNT_BITS'(1), "set count did not drop on merge")
   `KUFE_ASSERT_HOLDS(a_sets_bounded, set_total_ff <= set_limit, "set count above active count plus one")
   `KUFE_ASSERT_IMPLIES(a_accept_not_bad, rsp_valid_ff, !(rsp_acc_ff && rsp_bad_ff), "edge with bad id reported as merged")

endmodule

`default_nettype wire

>>> dv/kufe_edge_checker.sv
// Checker for the union-find edge filter: tracks the store, predicts and compares results.
`timescale 1ns / 1ps

module kufe_edge_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [kufe_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [kufe_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   input  wire logic                                req_tvalid,
   input  wire logic                                req_tready,
   // [11:0] from_vertex, [23:12] to_vertex
   input  wire logic [kufe_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] accepted, [3:1] direction, [16:4] sets_left, [23:17] zero
   input  wire logic [kufe_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // [0] bad_vertex
   input  wire logic                                rsp_tuser,
   output int                                       mismatch_count,
   output int                                       waiting_count,
   output int                                       results_checked,
   output int                                       merge_count
);

   import kufe_pkg::*;

   typedef enum logic [2:0] {
      DIR_TOP,
      DIR_RIGHT,
      DIR_BOTTOM,
      DIR_LEFT,
      DIR_NONE
   } heading_type;

   typedef struct packed {
      logic                  accepted;
      logic [2:0]            heading;
      logic                  bad_id;
      logic [COUNT_BITS-1:0] sets_left;
   } edge_outcome_type;

   logic [ID_BITS-1:0]    vertex_parent [VERTEX_SLOTS];
   logic [RANK_BITS-1:0]  vertex_rank [VERTEX_SLOTS];
   logic [COUNT_BITS-1:0] sets_remaining;
   logic [WIDTH_BITS-1:0] width_cfg;
   logic [ID_BITS-1:0]    active_cfg;
   edge_outcome_type      expected_outcomes [$];

   function automatic int usable_ids();
      int n = int'(active_cfg);
      if (n > VERTEX_SLOTS - 1) begin
         n = VERTEX_SLOTS - 1;
      end
      return n;
   endfunction

   function automatic void restart_store();
      for (int v = 0; v < VERTEX_SLOTS; v++) begin
         vertex_parent[v] = ID_BITS'(v);
         vertex_rank[v]   = '0;
      end
      sets_remaining = COUNT_BITS'(usable_ids() + 1);
   endfunction

   // Walk to the root, then point every node on the path straight at it.
   function automatic int root_of(int v);
      int root = v;
      int hop;
      while (int'(vertex_parent[root]) != root) begin
         root = int'(vertex_parent[root]);
      end
      while (int'(vertex_parent[v]) != root) begin
         hop              = int'(vertex_parent[v]);
         vertex_parent[v] = ID_BITS'(root);
         v                = hop;
      end
      return root;
   endfunction

   // First match wins: top, right, bottom, left.
   function automatic heading_type heading_of(int a, int b);
      int w = int'(width_cfg);
      if (w == 0) begin
         return DIR_NONE;
      end
      if (b + w == a) begin
         return DIR_TOP;
      end
      if (b == a + 1 && (b % w) != 1) begin
         return DIR_RIGHT;
      end
      if (b == a + w && b <= usable_ids()) begin
         return DIR_BOTTOM;
      end
      if (b + 1 == a && (b % w) != 0) begin
         return DIR_LEFT;
      end
      return DIR_NONE;
   endfunction

   function automatic edge_outcome_type filter_edge(int a, int b);
      edge_outcome_type res;
      int lim = usable_ids();
      int ra;
      int rb;
      res.accepted = 1'b0;
      res.heading  = DIR_NONE;
      res.bad_id   = 1'b0;
      if (a == 0 || b == 0 || a > lim || b > lim) begin
         res.bad_id = 1'b1;
      end else begin
         ra          = root_of(a);
         rb          = root_of(b);
         res.heading = heading_of(a, b);
         if (ra != rb) begin
            if (vertex_rank[ra] < vertex_rank[rb]) begin
               vertex_parent[ra] = ID_BITS'(rb);
            end else if (vertex_rank[ra] > vertex_rank[rb]) begin
               vertex_parent[rb] = ID_BITS'(ra);
            end else begin
               vertex_parent[rb] = ID_BITS'(ra);
               if (vertex_rank[ra] != RANK_MAX) begin
                  vertex_rank[ra] = vertex_rank[ra] + 1'b1;
               end
            end
            if (sets_remaining > 1) begin
               sets_remaining = sets_remaining - 1'b1;
            end
            res.accepted = 1'b1;
         end
      end
      res.sets_left = sets_remaining;
      return res;
   endfunction

   always @(posedge clock) begin
      edge_outcome_type want;
      edge_outcome_type got;
      logic [RSP_DATA_BITS-18:0] pad;
      if (reset) begin
         width_cfg  = GRID_WIDTH_RESET;
         active_cfg = ACTIVE_RESET;
         restart_store();
         expected_outcomes.delete();
         mismatch_count  = 0;
         results_checked = 0;
         merge_count     = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_GRID_WIDTH) begin
               width_cfg = csr_wr_data[WIDTH_BITS-1:0];
            end else if (csr_index == CSR_ACTIVE_VERTICES) begin
               active_cfg = csr_wr_data[ID_BITS-1:0];
               restart_store();
            end
         end
         if (req_tvalid && req_tready) begin
            want = filter_edge(int'(req_tdata[ID_BITS-1:0]),
                               int'(req_tdata[2*ID_BITS-1:ID_BITS]));
            expected_outcomes = {expected_outcomes, want};
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[0], rsp_tdata[3:1], rsp_tuser, rsp_tdata[16:4]};
            pad = rsp_tdata[RSP_DATA_BITS-1:17];
            results_checked++;
            if (expected_outcomes.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result word: accepted=%0d dir=%0d bad=%0d sets=%0d",
                        $time, got.accepted, got.heading, got.bad_id, got.sets_left);
            end else begin
               want = expected_outcomes.pop_front();
               if (got != want || pad != '0) begin
                  mismatch_count++;
                  $display("%0t: expected accepted=%0d dir=%0d bad=%0d sets=%0d pad=0",
                           $time, want.accepted, want.heading, want.bad_id, want.sets_left);
                  $display("%0t: actual   accepted=%0d dir=%0d bad=%0d sets=%0d pad=%0h",
                           $time, got.accepted, got.heading, got.bad_id, got.sets_left, pad);
               end
               if (want.accepted) begin
                  merge_count++;
               end
            end
         end
      end
      waiting_count = expected_outcomes.size();
   end

endmodule

>>> dv/tb_top.sv
// Testbench top: edge stimulus, register settings and verdict for the edge filter.
`timescale 1ns / 1ps

module tb_top;
   import kufe_pkg::*;

   // Kinds of off-grid words mixed into the shuffled edge streams.
   typedef enum int {
      NOISE_ANY,
      NOISE_ZERO,
      NOISE_HIGH,
      NOISE_SAME,
      NOISE_FAR
   } noise_kind_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data;
   logic                      req_tvalid;
   wire logic                 req_tready;
   // [11:0] from_vertex, [23:12] to_vertex
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   wire logic                 rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // [0] accepted, [3:1] direction, [16:4] sets_left, [23:17] zero
   wire logic [RSP_DATA_BITS-1:0] rsp_tdata;
   // [0] bad_vertex
   wire logic                 rsp_tuser;

   int mismatch_count;
   int waiting_count;
   int results_checked;
   int merge_count;

   int send_idle_pct = 23;
   int recv_idle_pct = 50;
   int edges_sent    = 0;
   int reg_writes    = 0;

   kruskal_union_find_edge_filter_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   kufe_edge_checker u_checker (.*);

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver side: stall rsp words at the rate of the current idle mode.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Hard stop. The slowest legal run (long find walks, long stalls on both
   // sides, one clearing pass of the whole store per active_vertices write)
   // stays well under a fifth of this.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Drive one edge word; idle first at the sender rate, then hold until taken.
   // Idle modes advance with the word count: sender-light/receiver-heavy,
   // then the reverse, then both sides at full rate.
   task automatic send_edge(input int from_id, input int to_id);
      if (edges_sent < 300) begin
         send_idle_pct = 23;
         recv_idle_pct = 50;
      end else if (edges_sent < 600) begin
         send_idle_pct = 50;
         recv_idle_pct = 23;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ID_BITS'(to_id), ID_BITS'(from_id)};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      edges_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every result word has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (waiting_count != 0) begin
         @(negedge clock);
      end
   endtask

   // One register write; the block is idle whenever this is called.
   task automatic set_reg(input logic [CSR_INDEX_BITS-1:0] idx, input int value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      reg_writes++;
      @(negedge clock);
   endtask

   // Off-grid word: random ids, a zero id, an id past the active count,
   // a self loop or a random pair of valid ids.
   task automatic send_noise(input int n);
      noise_kind_type kind;
      int             v;
      kind = noise_kind_type'($urandom_range(NOISE_FAR));
      v    = $urandom_range(n, 1);
      case (kind)
         NOISE_ANY: begin
            send_edge($urandom_range(4095), $urandom_range(4095));
         end
         NOISE_ZERO: begin
            if ($urandom_range(1)) begin
               send_edge(0, v);
            end else begin
               send_edge(v, 0);
            end
         end
         NOISE_HIGH: begin
            if (n < 4095) begin
               send_edge(v, $urandom_range(4095, n + 1));
            end else begin
               send_edge(0, 0);
            end
         end
         NOISE_SAME: begin
            send_edge(v, v);
         end
         default: begin
            send_edge(v, $urandom_range(n, 1));
         end
      endcase
   endtask

   // Kruskal pass over a w-wide grid of n rooms: every right and bottom edge up
   // to cap, shuffled, random orientation, with about one noise word in ten.
   task automatic run_grid(input int w, input int n, input int cap);
      int pairs [$];
      int j;
      int tmp;
      int a;
      int b;
      for (int v = 1; v <= n; v++) begin
         if (v % w != 0 && v + 1 <= n) begin
            pairs = {pairs, v | ((v + 1) << ID_BITS)};
         end
         if (v + w <= n) begin
            pairs = {pairs, v | ((v + w) << ID_BITS)};
         end
      end
      for (int i = pairs.size() - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         tmp      = pairs[i];
         pairs[i] = pairs[j];
         pairs[j] = tmp;
      end
      if (cap < pairs.size()) begin
         pairs = pairs[0:cap-1];
      end
      foreach (pairs[i]) begin
         a = pairs[i] & 12'hFFF;
         b = pairs[i] >> ID_BITS;
         if ($urandom_range(1)) begin
            send_edge(b, a);
         end else begin
            send_edge(a, b);
         end
         if ($urandom_range(9) == 0) begin
            send_noise(n);
         end
      end
      drain();
   endtask

   initial begin
      csr_wr_en   = 1'b0;
      csr_index   = CSR_GRID_WIDTH;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed words on the reset setting: 63 wide, 3969 rooms.
      send_edge(0, 5);          // zero first id
      send_edge(5, 0);          // zero second id
      send_edge(0, 0);
      send_edge(4095, 1);       // first id past the active count
      send_edge(1, 3970);       // second id just past it
      send_edge(4095, 4095);
      send_edge(3969, 3968);    // last room, left
      send_edge(7, 7);          // same room twice
      send_edge(100, 37);       // top
      send_edge(37, 38);        // right
      send_edge(38, 101);       // bottom
      send_edge(101, 100);      // left
      send_edge(100, 38);       // already joined, not neighbors
      send_edge(37, 100);       // already joined, direction still reported
      send_edge(63, 64);        // row wrap blocks right
      send_edge(127, 126);      // row wrap blocks left
      send_edge(1, 3969);       // far pair merges anyway
      send_edge(3969, 1);
      send_edge(1, 2);
      send_edge(2, 1);
      send_edge(2048, 3000);
      drain();

      // Smallest legal grid, then a width change that keeps the store.
      set_reg(CSR_GRID_WIDTH, 7);
      set_reg(CSR_ACTIVE_VERTICES, 49);
      run_grid(7, 49, 1000);
      set_reg(CSR_GRID_WIDTH, 9);
      run_grid(9, 49, 1000);

      set_reg(CSR_GRID_WIDTH, 11);
      set_reg(CSR_ACTIVE_VERTICES, 121);
      run_grid(11, 121, 1000);

      // Widest grid, every id in use; only a slice of its edges.
      set_reg(CSR_GRID_WIDTH, 63);
      set_reg(CSR_ACTIVE_VERTICES, 4095);
      run_grid(63, 4095, 220);

      // Zero width with a single room: nothing has a direction.
      set_reg(CSR_GRID_WIDTH, 0);
      set_reg(CSR_ACTIVE_VERTICES, 1);
      send_edge(1, 1);
      repeat (10) begin
         send_edge($urandom_range(2), $urandom_range(2));
      end
      send_edge($urandom_range(4095), $urandom_range(4095));
      drain();

      // No rooms at all: every id is bad.
      set_reg(CSR_GRID_WIDTH, 2);
      set_reg(CSR_ACTIVE_VERTICES, 0);
      send_edge(1, 2);
      repeat (7) begin
         send_edge($urandom_range(4095), $urandom_range(4095));
      end
      drain();

      // Partial last row: bottom edges run out before the row does.
      set_reg(CSR_GRID_WIDTH, 13);
      set_reg(CSR_ACTIVE_VERTICES, 100);
      run_grid(13, 100, 1000);

      // Let the output register settle before the verdict.
      repeat (64) @(posedge clock);
      $display("Covered %0d edge words over %0d register writes (grid widths 0 to 63).",
               edges_sent, reg_writes);
      $display("Checked %0d result words, %0d of them merges.", results_checked, merge_count);
      if (mismatch_count == 0 && waiting_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/kufe_pkg.sv
hdl/kufe_ram.sv
hdl/kruskal_union_find_edge_filter_unit.sv
dv/kufe_edge_checker.sv
dv/tb_top.sv
